/* rtl/assert_macros.svh */
// Assertion macros used by the top level of the sorted value table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SVT_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error("sorted value table assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define SVT_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error("sorted value table assertion failed");

`endif

/* rtl/svt_pkg.sv */
// Package with the operation codes, status codes and cell control type of the sorted value table.
`timescale 1ns / 1ps
package svt_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  typedef logic [VALUE_W-1:0] value_t;

  typedef struct packed {
    logic   ins_en;
    logic   del_en;
    value_t value;
  } cell_ctrl_t;

endpackage

/* rtl/sorted_value_table.sv */
// Top level of the sorted value table: a chain of compare-and-shift cells with stream ports.
//
//   Channel  Direction  tdata fields (lowest bit first)
//   in_      slave      operation[1:0], item_value[33:2], zero fill [39:34]
//   out_     master     status[1:0], found[2], entry_count[7:3]
//
// Every cell compares its entry with the item in the same cycle, so one transaction is
// taken per cycle while the output is not stalled, and its result is registered on acceptance.
// The per-cycle path is the signed compare in each cell plus the OR of all match flags.
// Reset empties the table at once; entry registers carry no reset.
// A stalled output holds its result and blocks new input transactions.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sorted_value_table
  import svt_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // operation[1:0], item_value[33:2], zeros[39:34]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // status[1:0], found[2], entry_count[7:3]
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [OP_W-1:0]     in_op;
  value_t              in_value;
  logic                in_fire;
  logic [CW-1:0]       cnt_r;
  logic [CW-1:0]       cnt_nxt;
  logic                full;
  logic                empty;
  logic                any_match;
  cell_ctrl_t          ctrl;
  value_t              entries [CAPACITY];
  logic [CAPACITY-1:0] shifts;
  logic [CAPACITY-1:0] match_flags;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [STATUS_W-1:0] status_r;
  logic [STATUS_W-1:0] status_nxt;
  logic                found_r;
  logic                found_nxt;
  logic [COUNT_W-1:0]  count_out_r;
  logic [CW+COUNT_W-1:0] cnt_ext;

  assign in_op     = in_tdata[OP_W-1:0];
  assign in_value  = in_tdata[OP_W+VALUE_W-1:OP_W];
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  assign full      = (cnt_r == CW'(CAPACITY));
  assign empty     = (cnt_r == '0);
  assign any_match = |match_flags;

  assign ctrl.ins_en = in_fire && (in_op == OP_INSERT) && !full;
  assign ctrl.del_en = in_fire && (in_op == OP_DELETE) && any_match;
  assign ctrl.value  = in_value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    value_t left_entry;
    logic   left_shift;
    value_t right_entry;

    if (i == 0) begin : g_first
      assign left_entry = '0;
      assign left_shift = 1'b0;
    end else begin : g_mid
      assign left_entry = entries[i-1];
      assign left_shift = shifts[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    svt_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .count       (cnt_r),
      .left_entry  (left_entry),
      .left_shift  (left_shift),
      .right_entry (right_entry),
      .entry       (entries[i]),
      .shift       (shifts[i]),
      .match       (match_flags[i])
    );
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctrl.ins_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (ctrl.del_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_comb begin
    status_nxt = ST_OK;
    found_nxt  = 1'b0;
    unique case (in_op)
      OP_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end
      end
      OP_DELETE: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else if (any_match) begin
          found_nxt = 1'b1;
        end else begin
          status_nxt = ST_MISSING;
        end
      end
      OP_FIND: begin
        if (any_match) begin
          found_nxt = 1'b1;
        end else begin
          status_nxt = ST_MISSING;
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  assign out_valid_nxt = in_fire || (out_valid_r && !out_tready);
  assign cnt_ext       = {{COUNT_W{1'b0}}, cnt_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r    <= status_nxt;
      found_r     <= found_nxt;
      count_out_r <= cnt_ext[COUNT_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {count_out_r, found_r, status_r};

  `SVT_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, cnt_r <= CW'(CAPACITY))
  `SVT_ASSERT_NEXT(a_full_drop, clk, rst_n, in_fire && (in_op == OP_INSERT) && full,
                   (status_r == ST_FULL) && (cnt_r == $past(cnt_r)))
  `SVT_ASSERT_NEXT(a_delete_count, clk, rst_n, ctrl.del_en,
                   found_r && (cnt_r == CW'($past(cnt_r) - 1'b1)))
  `SVT_ASSERT_NEXT(a_result_after_accept, clk, rst_n, in_fire, out_valid_r)

endmodule

/* rtl/svt_cell.sv */
// One compare-and-shift cell of the sorted value table, holding a single entry.
`timescale 1ns / 1ps
module svt_cell
  import svt_pkg::*;
#(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 5
) (
  input  logic          clk,
  input  cell_ctrl_t    ctrl,
  input  logic [CW-1:0] count,
  input  value_t        left_entry,
  input  logic          left_shift,
  input  value_t        right_entry,
  output value_t        entry,
  output logic          shift,
  output logic          match
);

  value_t entry_r;
  value_t entry_nxt;
  logic   valid;
  logic   at_end;
  logic   less;

  assign valid  = (CW'(IDX) < count);
  assign at_end = (CW'(IDX) == count);
  assign less   = ($signed(ctrl.value) < $signed(entry_r));
  assign shift  = valid && less;
  assign match  = valid && (entry_r == ctrl.value);
  assign entry  = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins_en) begin
      if (left_shift) begin
        entry_nxt = left_entry;
      end else if (shift || at_end) begin
        entry_nxt = ctrl.value;
      end
    end else if (ctrl.del_en) begin
      if (shift || match) begin
        entry_nxt = right_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule
